>>> design/ci8_tile_palette_decoder_top_assert.svh
// Assertion macros for the CI8 tile palette decoder.
`ifndef CI8_TILE_PALETTE_DECODER_TOP_ASSERT_SVH
`define CI8_TILE_PALETTE_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CTP_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ctp assertion failed");
`define CTP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ctp assertion failed");
`else
`define CTP_ASSERT_NOW(name, clk, rstn, ante, cons)
`define CTP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

>>> design/ctp_pkg.sv
// Shared types, codes and channel scaling table for the CI8 tile palette decoder.
package ctp_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam int MAX_DIM       = 1024;
    localparam int DIM_W         = $clog2(MAX_DIM);
    localparam int COLOR_W       = 16;
    localparam int CFG_INDEX_W   = 1;
    localparam int ChanMax5      = 31;
    localparam int ChanMax8      = 255;

    typedef enum logic [1:0] {
        ACT_PALETTE = 2'd0,
        ACT_TILE    = 2'd1,
        ACT_PIXEL   = 2'd2,
        ACT_FINISH  = 2'd3
    } ctp_action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SHAPE  = 3'd1,
        ST_MISMATCH   = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_NO_TILE    = 3'd4,
        ST_EARLIER    = 3'd5
    } ctp_status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'd0,
        REG_IMAGE_HEIGHT = 1'd1
    } ctp_reg_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [PAL_ADDR_W-1:0] entry_index;
        logic [COLOR_W-1:0]    color_word;
        logic [DIM_W-1:0]      tile_width;
        logic [DIM_W-1:0]      tile_height;
        logic [PAL_ADDR_W-1:0] index_byte;
    } ctp_in_t;

    typedef struct packed {
        ctp_status_t      status;
        logic             pixel_valid;
        logic [DIM_W-1:0] pos_x;
        logic [DIM_W-1:0] pos_y;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             image_complete;
    } ctp_out_t;

    typedef struct packed {
        ctp_status_t      status;
        logic             pixel_valid;
        logic [DIM_W-1:0] pos_x;
        logic [DIM_W-1:0] pos_y;
        logic             image_complete;
    } ctp_stage_t;

    function automatic logic [31:0][7:0] build_scale_lut();
        logic [31:0][7:0] lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = 8'((i * ChanMax8) / ChanMax5);
        end
        return lut;
    endfunction

    localparam logic [31:0][7:0] SCALE_LUT = build_scale_lut();

    function automatic logic [7:0] scale5(input logic [4:0] v);
        return SCALE_LUT[v];
    endfunction

endpackage

>>> design/ctp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ctp_place.sv
// Tile placement control, configuration registers and per-item status.
`include "ci8_tile_palette_decoder_top_assert.svh"
module ctp_place import ctp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  ctp_in_t                in_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_wdata,
    output ctp_stage_t             info
);

    logic [DIM_W-1:0] iw_reg, iw_next, ih_reg, ih_next;
    logic [DIM_W-1:0] px_reg, px_next, py_reg, py_next, strip_reg, strip_next;
    logic [DIM_W-1:0] otw_reg, otw_next, oth_reg, oth_next;
    logic [DIM_W-1:0] col_reg, col_next, row_reg, row_next;
    logic             open_reg, open_next, failed_reg, failed_next;

    logic [DIM_W-1:0] tw, th, x_in_tile, px_adv, py_adv;
    logic             bad_shape, col_wrap, row_last;

    assign tw = in_data.tile_width;
    assign th = in_data.tile_height;

    assign bad_shape = open_reg || (tw == '0) || (tw[2:0] != 3'd0) || (th == '0)
        || (tw > iw_reg) || (th > ih_reg)
        || (({1'b0, px_reg} + {1'b0, tw}) > {1'b0, iw_reg})
        || (({1'b0, py_reg} + {1'b0, th}) > {1'b0, ih_reg});

    assign x_in_tile = col_reg ^ {{(DIM_W-3){1'b0}}, row_reg[0], 2'b00};
    assign col_wrap  = ({1'b0, col_reg} + 11'd1) >= {1'b0, otw_reg};
    assign row_last  = ({1'b0, row_reg} + 11'd1) >= {1'b0, oth_reg};
    assign px_adv    = px_reg + otw_reg;
    assign py_adv    = py_reg + strip_reg;

    always_comb begin
        iw_next     = iw_reg;
        ih_next     = ih_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        strip_next  = strip_reg;
        otw_next    = otw_reg;
        oth_next    = oth_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        open_next   = open_reg;
        failed_next = failed_reg;
        info        = '0;
        info.status = ST_OK;

        if (cfg_wr_en) begin
            case (ctp_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  iw_next = cfg_wdata;
                REG_IMAGE_HEIGHT: ih_next = cfg_wdata;
                default: ;
            endcase
        end

        if (accept) begin
            case (ctp_action_t'(in_data.action))
                ACT_PALETTE: ;
                ACT_TILE: begin
                    if (failed_reg) begin
                        info.status = ST_EARLIER;
                    end else if (bad_shape) begin
                        info.status = ST_BAD_SHAPE;
                        failed_next = 1'b1;
                    end else if (px_reg != '0 && strip_reg != th) begin
                        info.status = ST_MISMATCH;
                        failed_next = 1'b1;
                    end else begin
                        strip_next = th;
                        otw_next   = tw;
                        oth_next   = th;
                        col_next   = '0;
                        row_next   = '0;
                        open_next  = 1'b1;
                    end
                end
                ACT_PIXEL: begin
                    if (failed_reg) begin
                        info.status = ST_EARLIER;
                    end else if (!open_reg) begin
                        info.status = ST_NO_TILE;
                        failed_next = 1'b1;
                    end else begin
                        info.pixel_valid = 1'b1;
                        info.pos_x       = px_reg + x_in_tile;
                        info.pos_y       = py_reg + row_reg;
                        col_next         = col_reg + 10'd1;
                        if (col_wrap) begin
                            col_next = '0;
                            row_next = row_reg + 10'd1;
                            if (row_last) begin
                                row_next  = '0;
                                open_next = 1'b0;
                                px_next   = px_adv;
                                if (px_adv == iw_reg) begin
                                    px_next = '0;
                                    py_next = py_adv;
                                end
                            end
                        end
                    end
                end
                ACT_FINISH: begin
                    if (failed_reg) begin
                        info.status = ST_EARLIER;
                    end else if (open_reg || py_reg != ih_reg || px_reg != '0) begin
                        info.status = ST_INCOMPLETE;
                    end else begin
                        info.image_complete = 1'b1;
                    end
                    px_next     = '0;
                    py_next     = '0;
                    strip_next  = '0;
                    otw_next    = '0;
                    oth_next    = '0;
                    col_next    = '0;
                    row_next    = '0;
                    open_next   = 1'b0;
                    failed_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg     <= 10'd160;
            ih_reg     <= 10'd120;
            px_reg     <= '0;
            py_reg     <= '0;
            strip_reg  <= '0;
            otw_reg    <= '0;
            oth_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            open_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end else begin
            iw_reg     <= iw_next;
            ih_reg     <= ih_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            strip_reg  <= strip_next;
            otw_reg    <= otw_next;
            oth_reg    <= oth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            open_reg   <= open_next;
            failed_reg <= failed_next;
        end
    end

    `CTP_ASSERT_NOW(a_open_width, aclk, aresetn, open_reg, (otw_reg != '0) && (otw_reg[2:0] == 3'd0))
    `CTP_ASSERT_NOW(a_col_range, aclk, aresetn, open_reg, col_reg < otw_reg)
    `CTP_ASSERT_NOW(a_row_range, aclk, aresetn, open_reg, row_reg < oth_reg)

endmodule

>>> design/ctp_color.sv
// Palette read stage, channel scaling and output register.
`include "ci8_tile_palette_decoder_top_assert.svh"
module ctp_color import ctp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  ctp_stage_t         info,
    input  logic [COLOR_W-1:0] pal_rdata,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ctp_out_t           m_data
);

    logic       s1_valid_reg, s1_valid_next;
    ctp_stage_t s1_info_reg;
    logic       m_valid_reg, m_valid_next;
    ctp_out_t   m_data_reg, m_data_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign in_ready = !s1_valid_reg || out_free;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next               = s1_valid_reg;
            m_data_next                = '0;
            m_data_next.status         = s1_info_reg.status;
            m_data_next.pixel_valid    = s1_info_reg.pixel_valid;
            m_data_next.pos_x          = s1_info_reg.pos_x;
            m_data_next.pos_y          = s1_info_reg.pos_y;
            m_data_next.image_complete = s1_info_reg.image_complete;
            if (s1_info_reg.pixel_valid) begin
                m_data_next.red   = scale5(pal_rdata[15:11]);
                m_data_next.green = scale5(pal_rdata[10:6]);
                m_data_next.blue  = scale5(pal_rdata[5:1]);
                m_data_next.alpha = pal_rdata[0] ? 8'd255 : 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg <= info;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CTP_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !out_free, s1_valid_reg)
    `CTP_ASSERT_NOW(a_no_overrun, aclk, aresetn, accept, !s1_valid_reg || out_free)
    `CTP_ASSERT_NEXT(a_s1_drains, aclk, aresetn, s1_valid_reg && out_free && !accept, m_valid_reg)

endmodule

>>> design/ci8_tile_palette_decoder_top.sv
// Top level of the CI8 tile palette decoder.
//
// Input beats on s_valid/s_ready carry one action each: palette write, tile
// start, pixel index byte or finish. Every input beat yields exactly one
// result beat on m_valid/m_ready, in order.
// After its input beat is accepted, a result passes the synchronous palette
// read stage and then the output register.
// Throughput: one beat per cycle while the receiver keeps up; tile placement
// state updates at accept and the palette lookup runs in the following stage,
// so pixels stream back to back.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) sets image_width
// (index 0) and image_height (index 1); write it only while the block is idle.
// Reset (aresetn low, synchronous) clears placement state and empties both
// stages, and sets the image to 160 x 120; palette contents are kept and are
// undefined until written.
// When the receiver stalls, the output register holds its beat, the read stage
// holds one more, and s_ready drops once both are full.
module ci8_tile_palette_decoder_top import ctp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ctp_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ctp_out_t               m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_wdata
);

    logic               accept;
    logic               pal_we, pal_re;
    logic [COLOR_W-1:0] pal_rdata;
    ctp_stage_t         info;

    assign accept = s_valid && s_ready;
    assign pal_we = accept && (ctp_action_t'(s_data.action) == ACT_PALETTE);
    assign pal_re = accept && (ctp_action_t'(s_data.action) == ACT_PIXEL);

    ctp_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s_data.entry_index),
        .wdata (s_data.color_word),
        .re    (pal_re),
        .raddr (s_data.index_byte),
        .rdata (pal_rdata)
    );

    ctp_place u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_data   (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .info      (info)
    );

    ctp_color u_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .info      (info),
        .pal_rdata (pal_rdata),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> sim/ci8_tile_palette_decoder_checker.sv
// Checker that decodes accepted input beats and compares each result beat of the tile decoder.
`timescale 1ns / 100ps
module ci8_tile_palette_decoder_checker import ctp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  ctp_in_t                s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  ctp_out_t               m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_wdata,
    output int                     mismatch_count,
    output int                     pending_beats,
    output int                     checked_beats,
    output int                     pixel_beats,
    output int                     complete_images
);

    logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
    logic [DIM_W-1:0]   image_w, image_h;
    logic [DIM_W-1:0]   place_x, place_y, strip_h;
    logic [DIM_W-1:0]   tile_w, tile_h, tile_col, tile_row;
    logic               tile_open, failed;
    ctp_out_t           decoded_beats [$];

    function automatic void clear_placement();
        place_x   = '0;
        place_y   = '0;
        strip_h   = '0;
        tile_w    = '0;
        tile_h    = '0;
        tile_col  = '0;
        tile_row  = '0;
        tile_open = 1'b0;
        failed    = 1'b0;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return 8'((int'(v) * 255) / 31);
    endfunction

    function automatic ctp_out_t decode_beat(input ctp_in_t beat);
        ctp_out_t           res;
        logic [COLOR_W-1:0] color;
        logic [DIM_W-1:0]   col_x;
        int                 tw, th;
        res = '0;
        res.status = ST_OK;
        tw = int'(beat.tile_width);
        th = int'(beat.tile_height);
        case (beat.action)
            ACT_PALETTE: begin
                palette[beat.entry_index] = beat.color_word;
            end
            ACT_TILE: begin
                if (failed) begin
                    res.status = ST_EARLIER;
                end else if (tile_open || tw == 0 || tw % 8 != 0 || th == 0
                             || tw > int'(image_w) || th > int'(image_h)
                             || int'(place_x) + tw > int'(image_w)
                             || int'(place_y) + th > int'(image_h)) begin
                    res.status = ST_BAD_SHAPE;
                    failed = 1'b1;
                end else if (place_x != 0 && int'(strip_h) != th) begin
                    res.status = ST_MISMATCH;
                    failed = 1'b1;
                end else begin
                    strip_h   = DIM_W'(th);
                    tile_w    = DIM_W'(tw);
                    tile_h    = DIM_W'(th);
                    tile_col  = '0;
                    tile_row  = '0;
                    tile_open = 1'b1;
                end
            end
            ACT_PIXEL: begin
                if (failed) begin
                    res.status = ST_EARLIER;
                end else if (!tile_open) begin
                    res.status = ST_NO_TILE;
                    failed = 1'b1;
                end else begin
                    color = palette[beat.index_byte];
                    // odd rows are stored with the column swizzled by four
                    col_x = tile_row[0] ? (tile_col ^ DIM_W'(4)) : tile_col;
                    res.pixel_valid = 1'b1;
                    res.pos_x = place_x + col_x;
                    res.pos_y = place_y + tile_row;
                    res.red   = widen5(color[15:11]);
                    res.green = widen5(color[10:6]);
                    res.blue  = widen5(color[5:1]);
                    res.alpha = color[0] ? 8'hFF : 8'h00;
                    tile_col = tile_col + 1'b1;
                    if (tile_col >= tile_w) begin
                        tile_col = '0;
                        tile_row = tile_row + 1'b1;
                        if (tile_row >= tile_h) begin
                            tile_row  = '0;
                            tile_open = 1'b0;
                            place_x   = place_x + tile_w;
                            if (place_x == image_w) begin
                                place_x = '0;
                                place_y = place_y + strip_h;
                            end
                        end
                    end
                end
            end
            default: begin
                if (failed) begin
                    res.status = ST_EARLIER;
                end else if (tile_open || place_y != image_h || place_x != 0) begin
                    res.status = ST_INCOMPLETE;
                end else begin
                    res.image_complete = 1'b1;
                end
                clear_placement();
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= 40) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            end
        end
    endtask

    always @(posedge aclk) begin
        ctp_out_t want;
        if (!aresetn) begin
            image_w = 10'd160;
            image_h = 10'd120;
            clear_placement();
            decoded_beats.delete();
            mismatch_count  = 0;
            checked_beats   = 0;
            pixel_beats     = 0;
            complete_images = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_beats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 40) begin
                        $display("%0t: result beat with none expected, got %h", $time, m_data);
                    end
                end else begin
                    want = decoded_beats.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_data.status));
                    compare_field("pixel_valid", 32'(want.pixel_valid),
                                  32'(m_data.pixel_valid));
                    compare_field("pos_x", 32'(want.pos_x), 32'(m_data.pos_x));
                    compare_field("pos_y", 32'(want.pos_y), 32'(m_data.pos_y));
                    compare_field("red", 32'(want.red), 32'(m_data.red));
                    compare_field("green", 32'(want.green), 32'(m_data.green));
                    compare_field("blue", 32'(want.blue), 32'(m_data.blue));
                    compare_field("alpha", 32'(want.alpha), 32'(m_data.alpha));
                    compare_field("image_complete", 32'(want.image_complete),
                                  32'(m_data.image_complete));
                    checked_beats++;
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    image_w = cfg_wdata;
                end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                    image_h = cfg_wdata;
                end
            end
            if (s_valid && s_ready) begin
                want = decode_beat(s_data);
                if (want.pixel_valid) pixel_beats++;
                if (want.image_complete) complete_images++;
                decoded_beats.insert(decoded_beats.size(), want);
            end
        end
        pending_beats = decoded_beats.size();
    end

endmodule

>>> sim/ci8_tile_palette_decoder_top_tb.sv
// Testbench top for the tile decoder: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module ci8_tile_palette_decoder_top_tb;
    import ctp_pkg::*;

    typedef enum int {
        F_ZERO_WIDTH,
        F_ODD_WIDTH,
        F_ZERO_HEIGHT,
        F_TOO_WIDE,
        F_TOO_TALL,
        F_HEIGHT_MISMATCH,
        F_TILE_WHILE_OPEN,
        F_PIXEL_NO_TILE,
        F_OPEN_AT_FINISH,
        F_EARLY_FINISH
    } fault_kind_t;

    localparam int NUM_SETTINGS = 9;
    localparam int SET_W [NUM_SETTINGS] = '{16, 8, 1023, 24, 8, 1016, 40, 32, 64};
    localparam int SET_H [NUM_SETTINGS] = '{4, 1, 1023, 3, 1023, 1, 2, 6, 3};

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    ctp_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    ctp_out_t               m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIM_W-1:0]       cfg_wdata;

    int mismatch_count, pending_beats, checked_beats, pixel_beats, complete_images;
    int cur_width, cur_height, sent_beats, got_beats, setting_count;

    logic pal_written [PALETTE_DEPTH];
    int   written_list [$];

    ci8_tile_palette_decoder_top dut (.*);

    ci8_tile_palette_decoder_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [PAL_ADDR_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, PALETTE_DEPTH - 1);
        if (pal_written[r] || written_list.size() == 0) return PAL_ADDR_W'(r);
        return PAL_ADDR_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    function automatic ctp_in_t random_beat(input ctp_action_t act);
        logic [63:0] raw;
        ctp_in_t     beat;
        raw = {$urandom, $urandom};
        beat = raw[$bits(ctp_in_t)-1:0];
        beat.action = act;
        beat.index_byte = pick_index();
        return beat;
    endfunction

    task automatic send_beat(input ctp_in_t beat);
        int gap;
        gap = ((sent_beats / 128) % 3 == 2) ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        if (beat.action == ACT_PALETTE && !pal_written[beat.entry_index]) begin
            pal_written[beat.entry_index] = 1'b1;
            written_list.insert(written_list.size(), int'(beat.entry_index));
        end
        sent_beats++;
    endtask

    task automatic send_palette(input int idx, input logic [COLOR_W-1:0] color);
        ctp_in_t beat;
        beat = random_beat(ACT_PALETTE);
        beat.entry_index = PAL_ADDR_W'(idx);
        beat.color_word  = color;
        send_beat(beat);
    endtask

    task automatic send_tile(input int tw, input int th);
        ctp_in_t beat;
        beat = random_beat(ACT_TILE);
        beat.tile_width  = DIM_W'(tw);
        beat.tile_height = DIM_W'(th);
        send_beat(beat);
    endtask

    task automatic send_pixels(input int n);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) begin
                send_palette($urandom_range(0, 255), COLOR_W'($urandom));
            end
            send_beat(random_beat(ACT_PIXEL));
        end
    endtask

    task automatic send_finish();
        send_beat(random_beat(ACT_FINISH));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_beat(random_beat(ctp_action_t'($urandom_range(0, 3))));
    endtask

    task automatic inject_fault(input int px, input int py, input int h);
        case (fault_kind_t'($urandom_range(0, F_EARLY_FINISH)))
            F_ZERO_WIDTH:      send_tile(0, h);
            F_ODD_WIDTH:       send_tile(8 * $urandom_range(0, 126) + $urandom_range(1, 7), h);
            F_ZERO_HEIGHT:     send_tile(8, 0);
            F_TOO_WIDE:        send_tile(8 * $urandom_range((cur_width - px) / 8 + 1, 127), h);
            F_TOO_TALL:        send_tile(8, cur_height - py + 1);
            F_HEIGHT_MISMATCH: send_tile(8, h + $urandom_range(1, 2));
            F_TILE_WHILE_OPEN: begin
                send_tile(8, h);
                send_pixels($urandom_range(0, 7));
                send_tile(8, h);
            end
            F_PIXEL_NO_TILE:   send_pixels(1);
            F_OPEN_AT_FINISH: begin
                send_tile(8, h);
                send_pixels($urandom_range(1, 8 * h - 1));
            end
            default: ;
        endcase
        send_noise($urandom_range(0, 4));
    endtask

    task automatic send_image(input bit broken);
        int py, px, h, tw, tiles, max_tiles;
        bit stop, faulted;
        py = 0;
        tiles = 0;
        stop = 1'b0;
        faulted = 1'b0;
        max_tiles = (cur_width * cur_height <= 256) ? 64 : 6;
        while (!stop && py < cur_height) begin
            h = $urandom_range(1, (cur_height - py < 3) ? cur_height - py : 3);
            px = 0;
            while (!stop && px < cur_width) begin
                if (cur_width - px < 8 || tiles >= max_tiles) begin
                    stop = 1'b1;
                end else if (broken && $urandom_range(0, 3) == 0) begin
                    inject_fault(px, py, h);
                    stop = 1'b1;
                    faulted = 1'b1;
                end else begin
                    tw = 8 * $urandom_range(1, ((cur_width - px) / 8 < 3) ?
                                               (cur_width - px) / 8 : 3);
                    send_tile(tw, h);
                    send_pixels(tw * h);
                    px += tw;
                    tiles++;
                end
            end
            py += h;
        end
        if (broken && !faulted) inject_fault(0, py, 1);
        send_finish();
    endtask

    task automatic wait_idle(input int tail);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_beats != 0) @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    task automatic write_reg(input ctp_reg_t idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= DIM_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_image(input int w, input int h);
        wait_idle(4);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cur_width  = w;
        cur_height = h;
        setting_count++;
    endtask

    // receiver: random stalls, bursts of full rate, and two long hold-offs
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (got_beats == 400 || got_beats == 1400) begin
                gap = 200;
            end else begin
                gap = ((got_beats / 96) % 3 == 1) ? 0 : $urandom_range(0, 11);
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got_beats++;
        end
    end

    initial begin
        int phase;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_IMAGE_WIDTH;
        cfg_wdata  = '0;
        cur_width  = 160;
        cur_height = 120;
        sent_beats = 0;
        got_beats  = 0;
        setting_count = 1;
        for (int i = 0; i < PALETTE_DEPTH; i++) pal_written[i] = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_palette(0, 16'h0000);
        send_palette(255, 16'hFFFF);
        send_palette(8'hAA, 16'h5555);
        send_palette(8'h55, 16'hAAAA);
        send_pixels(1);
        send_tile(8, 2);
        send_pixels(1);
        send_finish();
        send_finish();
        send_tile(0, 1);
        send_finish();
        send_tile(1023, 1023);
        send_finish();
        send_tile(8, 2);
        send_pixels(9);
        send_finish();

        phase = 0;
        while (sent_beats < 1900) begin
            set_image(SET_W[phase % NUM_SETTINGS], SET_H[phase % NUM_SETTINGS]);
            repeat ($urandom_range(1, 3)) begin
                if (sent_beats < 1900) send_image($urandom_range(0, 3) == 0);
            end
            phase++;
        end

        wait_idle(20);
        $display("Run drove %0d input beats over %0d image sizes and checked %0d results,",
                 sent_beats, setting_count, checked_beats);
        $display("with %0d decoded pixels and %0d complete images among them.",
                 pixel_beats, complete_images);
        if (mismatch_count == 0 && pending_beats == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/ctp_pkg.sv
design/ctp_ram.sv
design/ctp_place.sv
design/ctp_color.sv
design/ci8_tile_palette_decoder_top.sv
sim/ci8_tile_palette_decoder_checker.sv
sim/ci8_tile_palette_decoder_top_tb.sv
